### hdl/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg: shared types and constants for the vector normalizer
// Fixed-point widths, stage counts and the item structs used on the ports
// and between the pipeline sections.
// ----------------------------------------------------------------------------
package vn_pkg;

    // Input components are signed Q8.8, results signed Q1.14.
    localparam int IN_W      = 16;
    localparam int FRAC      = 14;
    localparam int OUT_W     = FRAC + 2;
    localparam int MAG_W     = IN_W;
    // Squared length of three components, rounded up to an even width.
    localparam int SQ_W      = 2 * IN_W + 2;
    localparam int ROOT_W    = SQ_W / 2;
    localparam int SQ_STEPS  = SQ_W / 2;
    localparam int DIV_STEPS = FRAC + 1;
    // Front end (3) + root steps + divide steps + output register.
    localparam int LATENCY   = 3 + SQ_STEPS + DIV_STEPS + 1;

    typedef struct packed {
        logic signed [IN_W-1:0] vec_x;
        logic signed [IN_W-1:0] vec_y;
        logic signed [IN_W-1:0] vec_z;
    } vn_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] unit_x;
        logic signed [OUT_W-1:0] unit_y;
        logic signed [OUT_W-1:0] unit_z;
        logic                    was_zero;
    } vn_out_t;

    // Per-item data that rides along with the root and divide stages.
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  zero;
    } vn_side_t;

endpackage

### hdl/vn_sqrt.sv
// ----------------------------------------------------------------------------
// vn_sqrt: pipelined integer square root
// One result bit per stage, rounded down, with per-item side data carried
// along each stage.
// ----------------------------------------------------------------------------
module vn_sqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [vn_pkg::SQ_W-1:0]   in_sq,
    input  vn_pkg::vn_side_t          in_side,
    output logic                      out_valid,
    output logic [vn_pkg::ROOT_W-1:0] out_root,
    output vn_pkg::vn_side_t          out_side
);
    import vn_pkg::*;

    localparam int REM_W = ROOT_W + 2;

    logic              valid_reg [1:SQ_STEPS];
    logic [SQ_W-1:0]   bits_reg  [1:SQ_STEPS];
    logic [REM_W-1:0]  rem_reg   [1:SQ_STEPS];
    logic [ROOT_W-1:0] root_reg  [1:SQ_STEPS];
    vn_side_t          side_reg  [1:SQ_STEPS];

    genvar i;
    generate
        for (i = 0; i < SQ_STEPS; i++) begin : g_step
            logic              v_cur;
            logic [SQ_W-1:0]   bits_cur;
            logic [REM_W-1:0]  rem_cur;
            logic [ROOT_W-1:0] root_cur;
            vn_side_t          side_cur;
            logic [REM_W-1:0]  rem_sh;
            logic [REM_W-1:0]  trial;
            logic [REM_W-1:0]  rem_next;
            logic [ROOT_W-1:0] root_next;

            // Stage inputs: the ports for the first step, else the previous step.
            if (i == 0) begin : g_first
                assign v_cur    = in_valid;
                assign bits_cur = in_sq;
                assign rem_cur  = '0;
                assign root_cur = '0;
                assign side_cur = in_side;
            end else begin : g_rest
                assign v_cur    = valid_reg[i];
                assign bits_cur = bits_reg[i];
                assign rem_cur  = rem_reg[i];
                assign root_cur = root_reg[i];
                assign side_cur = side_reg[i];
            end

            // Bring down two bits and try to subtract 4*root + 1.
            always_comb
            begin
                rem_sh = {rem_cur[REM_W-3:0], bits_cur[SQ_W-1:SQ_W-2]};
                trial  = {root_cur, 2'b01};
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_cur[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_cur[ROOT_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[i+1] <= 1'b0;
                else
                    valid_reg[i+1] <= v_cur;
            end

            always_ff @(posedge clk)
            begin
                bits_reg[i+1] <= {bits_cur[SQ_W-3:0], 2'b00};
                rem_reg[i+1]  <= rem_next;
                root_reg[i+1] <= root_next;
                side_reg[i+1] <= side_cur;
            end
        end
    endgenerate

    assign out_valid = valid_reg[SQ_STEPS];
    assign out_root  = root_reg[SQ_STEPS];
    assign out_side  = side_reg[SQ_STEPS];

endmodule

### hdl/vn_div.sv
// ----------------------------------------------------------------------------
// vn_div: pipelined three-lane divider
// Divides each component magnitude, scaled to the output fraction, by the
// length, one quotient bit per stage, truncating.
// ----------------------------------------------------------------------------
module vn_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [vn_pkg::ROOT_W-1:0]  in_len,
    input  vn_pkg::vn_side_t           in_side,
    output logic                       out_valid,
    output logic [2:0][vn_pkg::FRAC:0] out_quo,
    output vn_pkg::vn_side_t           out_side
);
    import vn_pkg::*;

    logic                   valid_reg [1:DIV_STEPS];
    logic [ROOT_W-1:0]      len_reg   [1:DIV_STEPS];
    logic [2:0][ROOT_W-1:0] rem_reg   [1:DIV_STEPS];
    logic [2:0][FRAC:0]     quo_reg   [1:DIV_STEPS];
    vn_side_t               side_reg  [1:DIV_STEPS];

    genvar i, k;
    generate
        for (i = 0; i < DIV_STEPS; i++) begin : g_step
            logic                     v_cur;
            logic [ROOT_W-1:0]        len_cur;
            vn_side_t                 side_cur;
            logic [2:0][FRAC:0]       quo_cur;
            logic [2:0][ROOT_W:0]     rem_sh;
            logic [2:0][ROOT_W-1:0]   rem_next;
            logic [2:0][FRAC:0]       quo_next;

            // The first step takes the magnitude itself, which never exceeds
            // the length; later steps shift the remainder left by one.
            if (i == 0) begin : g_first
                assign v_cur    = in_valid;
                assign len_cur  = in_len;
                assign side_cur = in_side;
                assign quo_cur  = '0;
                for (k = 0; k < 3; k++) begin : g_lane
                    assign rem_sh[k] = {{(ROOT_W + 1 - MAG_W){1'b0}}, in_side.mag[k]};
                end
            end else begin : g_rest
                assign v_cur    = valid_reg[i];
                assign len_cur  = len_reg[i];
                assign side_cur = side_reg[i];
                assign quo_cur  = quo_reg[i];
                for (k = 0; k < 3; k++) begin : g_lane
                    assign rem_sh[k] = {rem_reg[i][k], 1'b0};
                end
            end

            // Compare and subtract in each lane.
            for (k = 0; k < 3; k++) begin : g_cmp
                always_comb
                begin
                    if (rem_sh[k] >= {1'b0, len_cur})
                    begin
                        rem_next[k] = ROOT_W'(rem_sh[k] - {1'b0, len_cur});
                        quo_next[k] = {quo_cur[k][FRAC-1:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[k] = rem_sh[k][ROOT_W-1:0];
                        quo_next[k] = {quo_cur[k][FRAC-1:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[i+1] <= 1'b0;
                else
                    valid_reg[i+1] <= v_cur;
            end

            always_ff @(posedge clk)
            begin
                len_reg[i+1]  <= len_cur;
                rem_reg[i+1]  <= rem_next;
                quo_reg[i+1]  <= quo_next;
                side_reg[i+1] <= side_cur;
            end
        end
    endgenerate

    assign out_valid = valid_reg[DIV_STEPS];
    assign out_quo   = quo_reg[DIV_STEPS];
    assign out_side  = side_reg[DIV_STEPS];

endmodule

### hdl/vector3_normalize.sv
// ----------------------------------------------------------------------------
// vector3_normalize: 3D vector to unit vector, fully pipelined
// Squared length, integer square root and three divisions in one pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   An item (vec: three signed Q8.8 components) is taken at each rising edge
//   where start is high and busy is low. busy is always low, so a new item
//   can be given every cycle.
//   The result (unit: three signed Q1.14 components plus was_zero) appears
//   on unit for exactly one cycle, marked by done. The item passes through
//   three front-end stages (magnitude, squares, sum), one stage per root
//   bit (17) and one per quotient bit (15), then the output register.
//   Throughput is one item per cycle; results leave in input order.
//   A zero vector gives zero components with was_zero set.
//   The receiver cannot hold results off, so the pipeline never stalls.
//   Reset clears all valid bits; items in flight are dropped and no done
//   pulse follows until a new item is started.
// ----------------------------------------------------------------------------
module vector3_normalize (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  vn_pkg::vn_in_t  vec,
    output logic            done,
    output vn_pkg::vn_out_t unit
);
    import vn_pkg::*;

    // Stage 1: magnitudes and signs.
    logic                  s1_valid_reg;
    logic [2:0][MAG_W-1:0] s1_mag_reg;
    logic [2:0]            s1_neg_reg;
    logic [2:0][IN_W-1:0]  comp;

    // Stage 2: squares.
    logic                    s2_valid_reg;
    logic [2:0][2*MAG_W-1:0] s2_sqr_reg;
    vn_side_t                s2_side_reg;

    // Stage 3: squared length.
    logic            s3_valid_reg;
    logic [SQ_W-1:0] s3_sq_reg;
    vn_side_t        s3_side_reg;
    vn_side_t        s3_side_next;

    logic              rt_valid;
    logic [ROOT_W-1:0] rt_root;
    vn_side_t          rt_side;

    logic               dv_valid;
    logic [2:0][FRAC:0] dv_quo;
    vn_side_t           dv_side;

    logic    done_reg;
    vn_out_t unit_reg;
    vn_out_t unit_next;

    assign busy = 1'b0;
    assign comp = {vec.vec_x, vec.vec_y, vec.vec_z};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= dv_valid;
        end
    end

    // Magnitudes: the most negative value maps to its full magnitude.
    always_ff @(posedge clk)
    begin
        for (int n = 0; n < 3; n++)
        begin
            s1_neg_reg[n] <= comp[n][IN_W-1];
            s1_mag_reg[n] <= comp[n][IN_W-1] ? (~comp[n] + 1'b1) : comp[n];
        end
    end

    // One multiplier per component.
    always_ff @(posedge clk)
    begin
        for (int n = 0; n < 3; n++)
            s2_sqr_reg[n] <= s1_mag_reg[n] * s1_mag_reg[n];
        s2_side_reg.mag  <= s1_mag_reg;
        s2_side_reg.neg  <= s1_neg_reg;
        s2_side_reg.zero <= 1'b0;
    end

    // Sum of squares and the zero-vector flag.
    always_comb
    begin
        s3_side_next      = s2_side_reg;
        s3_side_next.zero = (s2_sqr_reg[0] == '0) && (s2_sqr_reg[1] == '0)
                            && (s2_sqr_reg[2] == '0);
    end

    always_ff @(posedge clk)
    begin
        s3_sq_reg   <= SQ_W'(s2_sqr_reg[0]) + SQ_W'(s2_sqr_reg[1])
                       + SQ_W'(s2_sqr_reg[2]);
        s3_side_reg <= s3_side_next;
    end

    vn_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_sq     (s3_sq_reg),
        .in_side   (s3_side_reg),
        .out_valid (rt_valid),
        .out_root  (rt_root),
        .out_side  (rt_side)
    );

    vn_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rt_valid),
        .in_len    (rt_root),
        .in_side   (rt_side),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    // Restore signs; a zero vector reads as zero with the flag set.
    always_comb
    begin
        logic [2:0][OUT_W-1:0] res;
        for (int n = 0; n < 3; n++)
        begin
            if (dv_side.zero)
                res[n] = '0;
            else if (dv_side.neg[n])
                res[n] = OUT_W'(-{1'b0, dv_quo[n]});
            else
                res[n] = OUT_W'({1'b0, dv_quo[n]});
        end
        unit_next.unit_x   = res[2];
        unit_next.unit_y   = res[1];
        unit_next.unit_z   = res[0];
        unit_next.was_zero = dv_side.zero;
    end

    always_ff @(posedge clk)
    begin
        unit_reg <= unit_next;
    end

    assign done = done_reg;
    assign unit = unit_reg;

endmodule

### hdl/vn_checker.sv
// ----------------------------------------------------------------------------
// vn_checker: port-level checks for the vector normalizer
// Watches the top-level ports for latency, idle and result-range rules.
// ----------------------------------------------------------------------------
module vn_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input logic            done,
    input vn_pkg::vn_out_t unit
);
    import vn_pkg::*;

    localparam logic signed [OUT_W-1:0] ONE  = OUT_W'(1) <<< FRAC;
    localparam logic signed [OUT_W-1:0] MONE = -ONE;

    // The block never holds off an item.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // Every item gives exactly one result, and no result comes without an item.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("result missing at expected cycle");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##LATENCY !done)
        else $error("result without an item");

    // A zero vector reads as all-zero components.
    a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && unit.was_zero) |->
            (unit.unit_x == '0 && unit.unit_y == '0 && unit.unit_z == '0))
        else $error("zero vector gave nonzero components");

    // Components never exceed one in magnitude.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (unit.unit_x <= ONE && unit.unit_x >= MONE
               && unit.unit_y <= ONE && unit.unit_y >= MONE
               && unit.unit_z <= ONE && unit.unit_z >= MONE))
        else $error("component out of range");

endmodule

bind vector3_normalize vn_checker u_vn_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .unit  (unit)
);

### test/tb_vector3_normalize.sv
// ----------------------------------------------------------------------------
// tb_vector3_normalize: self-checking bench for the vector normalizer
// Drives vectors through the start/busy handshake, predicts each unit vector
// with an integer square root and truncating divisions, and compares every
// done strobe against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_vector3_normalize;
    import vn_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    vn_in_t  vec;
    logic    done;
    vn_out_t unit;

    vn_out_t unit_queue[$];
    int      error_count;
    int      item_count;
    int      result_count;
    int      zero_count;
    int      idle_cycles;

    vector3_normalize dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .vec   (vec),
        .done  (done),
        .unit  (unit)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Floor of the square root of a 64-bit value.
    function automatic longint unsigned isqrt(input longint unsigned n);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned b;
        rem  = n;
        root = 0;
        b    = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (rem >= root + b)
            begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end
            else
                root >>= 1;
            b >>= 2;
        end
        return root;
    endfunction

    // Predicts the unit vector for one input vector.
    function automatic vn_out_t normalize_vector(input vn_in_t v);
        longint signed   comp[3];
        longint unsigned mag[3];
        longint unsigned sum;
        longint unsigned len;
        longint unsigned quo;
        logic [OUT_W-1:0] lane[3];
        vn_out_t r;
        comp[0] = v.vec_x;
        comp[1] = v.vec_y;
        comp[2] = v.vec_z;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (comp[i] < 0) ? -comp[i] : comp[i];
            sum += mag[i] * mag[i];
        end
        if (sum == 0)
        begin
            r = '0;
            r.was_zero = 1'b1;
            return r;
        end
        len = isqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            quo = (mag[i] << FRAC) / len;
            lane[i] = (comp[i] < 0) ? OUT_W'(-quo) : OUT_W'(quo);
        end
        r.unit_x   = lane[0];
        r.unit_y   = lane[1];
        r.unit_z   = lane[2];
        r.was_zero = 1'b0;
        return r;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 result_count, what, got, want);
    endtask

    // Sends one item after a random gap; the prediction is queued on accept.
    // start stays high after the accept so that a following item can go out
    // with no gap; it drops again only in a later gap or at the end of test_burst.
    task automatic send_vector(input logic [IN_W-1:0] x, input logic [IN_W-1:0] y,
                               input logic [IN_W-1:0] z);
        int gap;
        vn_in_t v;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 1) == 0)
            gap = 0;
        repeat (gap)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        v.vec_x = x;
        v.vec_y = y;
        v.vec_z = z;
        start <= 1'b1;
        vec   <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        unit_queue.push_back(normalize_vector(v));
        item_count++;
        @(negedge clk);
    endtask

    // Checks each done strobe against the oldest prediction.
    always @(posedge clk)
    begin
        vn_out_t want;
        if (rst_n && done)
        begin
            if (unit_queue.size() == 0)
            begin
                error_count++;
                $display("unexpected result with nothing pending");
            end
            else
            begin
                want = unit_queue.pop_front();
                if (unit.unit_x !== want.unit_x)
                    report_mismatch("unit_x", unit.unit_x, want.unit_x);
                if (unit.unit_y !== want.unit_y)
                    report_mismatch("unit_y", unit.unit_y, want.unit_y);
                if (unit.unit_z !== want.unit_z)
                    report_mismatch("unit_z", unit.unit_z, want.unit_z);
                if (unit.was_zero !== want.was_zero)
                    report_mismatch("was_zero", unit.was_zero, want.was_zero);
                if (want.was_zero)
                    zero_count++;
            end
            result_count++;
        end
    end

    // Watchdog on cycles with no accepted item or result.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Extremes, zero vector, axis-aligned and mixed-sign vectors.
    task automatic test_directed();
        send_vector(16'sh0000, 16'sh0000, 16'sh0000);
        send_vector(16'sh8000, 16'sh0000, 16'sh0000);
        send_vector(16'sh0000, 16'sh8000, 16'sh0000);
        send_vector(16'sh0000, 16'sh0000, 16'sh8000);
        send_vector(16'sh7FFF, 16'sh0000, 16'sh0000);
        send_vector(16'sh8000, 16'sh8000, 16'sh8000);
        send_vector(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_vector(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_vector(16'sh0001, 16'sh0000, 16'sh0000);
        send_vector(16'shFFFF, 16'sh0000, 16'sh0000);
        send_vector(16'sh0001, 16'sh0001, 16'sh0001);
        send_vector(16'shFFFF, 16'shFFFF, 16'shFFFF);
        send_vector(16'sh0003, 16'sh0004, 16'sh0000);
        send_vector(16'sh0000, 16'shFFFD, 16'sh0004);
        send_vector(16'sh0100, 16'shFF00, 16'sh0100);
        send_vector(16'sh5555, 16'shAAAA, 16'sh0000);
        send_vector(16'sh0000, 16'sh0000, 16'sh0000);
    endtask

    // Random vectors of mixed magnitude, with a few zeros and near-axis cases.
    task automatic test_random(input int count);
        logic [IN_W-1:0] c[3];
        int shift;
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                shift = $urandom_range(0, 15);
                c[i] = IN_W'($signed(IN_W'($urandom)) >>> shift);
                if ($urandom_range(0, 7) == 0)
                    c[i] = '0;
            end
            if ($urandom_range(0, 49) == 0)
                c = '{default: '0};
            send_vector(c[0], c[1], c[2]);
        end
    endtask

    // Back-to-back items with no gaps.
    task automatic test_burst(input int count);
        vn_in_t v;
        for (int n = 0; n < count; n++)
        begin
            v = vn_in_t'({$urandom, 16'($urandom)});
            start <= 1'b1;
            vec   <= v;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            unit_queue.push_back(normalize_vector(v));
            item_count++;
            @(negedge clk);
        end
        start <= 1'b0;
    endtask

    initial
    begin
        error_count  = 0;
        item_count   = 0;
        result_count = 0;
        zero_count   = 0;
        idle_cycles  = 0;
        start = 1'b0;
        vec   = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(700);
        test_burst(100);

        // Drain the pipeline, then allow extra cycles for stray strobes.
        while (unit_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("run covered %0d vectors and %0d results, %0d of them zero vectors",
                 item_count, result_count, zero_count);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
